### hdl/bounded_double_ended_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded double-ended queue unit
// Clocked on clk, disabled while arst_n is low; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// expression holds at every clock edge
`define BDEQ_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);
// consequent holds in the cycle after the antecedent
`define BDEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BDEQ_ASSERT_ALWAYS(lbl, expr, msg)
`define BDEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/bdeq_pkg.sv
// ----------------------------------------------------------------------------
// bdeq_pkg
// Request and status codes and controller/datapath command type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdeq_pkg;

	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 8;

	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ_FRONT = 3'd4;
	localparam logic [FUNC_W-1:0] FN_READ_BACK  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_READ_INDEX = 3'd6;
	localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd7;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INDEX = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic exec;     // request word accepted this cycle
		logic respond;  // result word on the ports this cycle
	} cmd_t;

endpackage

### hdl/bdeq_ctrl.sv
// ----------------------------------------------------------------------------
// bdeq_ctrl
// Two-state sequencer: accept a request word, then present its result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_double_ended_queue_unit_assert.svh"

module bdeq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output bdeq_pkg::cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RESP = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign busy        = (state_q == S_RESP);
	assign done        = (state_q == S_RESP);
	assign cmd.exec    = start && (state_q == S_IDLE);
	assign cmd.respond = (state_q == S_RESP);

	`BDEQ_ASSERT_NEXT(a_exec_then_resp, cmd.exec, cmd.respond, "accept not followed by result")
	`BDEQ_ASSERT_NEXT(a_resp_single, cmd.respond, !cmd.respond && !busy, "result held over")

endmodule

### hdl/bdeq_datapath.sv
// ----------------------------------------------------------------------------
// bdeq_datapath
// Ring store, front pointer, element count, slot address and result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_double_ended_queue_unit_assert.svh"

module bdeq_datapath #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32,
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bdeq_pkg::cmd_t                  cmd,
	input  logic [bdeq_pkg::FUNC_W-1:0]     func,
	input  logic [DATA_WIDTH-1:0]           value,
	input  logic [bdeq_pkg::POS_W-1:0]      position,
	output logic [DATA_WIDTH-1:0]           data_out,
	output logic [bdeq_pkg::STATUS_W-1:0]   status,
	output logic [CNT_W-1:0]                count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > bdeq_pkg::POS_W) ? CNT_W : bdeq_pkg::POS_W;

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [PTR_W-1:0]              front_q;
	logic [CNT_W-1:0]              count_q;
	logic [DATA_WIDTH-1:0]         rd_q;
	logic [bdeq_pkg::STATUS_W-1:0] status_q;
	logic                          show_q;

	logic                          full;
	logic                          empty;
	logic                          pos_bad;
	logic [PTR_W-1:0]              offset;
	logic [PTR_W:0]                sum;
	logic [PTR_W-1:0]              slot;
	logic [PTR_W-1:0]              front_dec;
	logic [PTR_W-1:0]              front_inc;
	logic                          we;
	logic                          use_dec;
	logic                          show_d;
	logic [bdeq_pkg::STATUS_W-1:0] status_d;
	logic [PTR_W-1:0]              front_d;
	logic [CNT_W-1:0]              count_d;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign pos_bad = (CMP_W'(position) >= CMP_W'(count_q));

	assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;

	// slot = (front + offset) mod DEPTH, offset < DEPTH; push front takes front - 1 mod DEPTH
	assign sum  = {1'b0, front_q} + {1'b0, offset};
	assign slot = use_dec ? front_dec
	            : ((sum >= (PTR_W + 1)'(DEPTH)) ? PTR_W'(sum - (PTR_W + 1)'(DEPTH))
	                                             : sum[PTR_W-1:0]);

	always_comb begin
		offset   = '0;
		use_dec  = 1'b0;
		we       = 1'b0;
		show_d   = 1'b0;
		status_d = bdeq_pkg::ST_OK;
		front_d  = front_q;
		count_d  = count_q;
		unique case (func)
			bdeq_pkg::FN_PUSH_FRONT: begin
				use_dec = 1'b1;
				if (full) status_d = bdeq_pkg::ST_FULL;
				else begin
					we      = 1'b1;
					front_d = front_dec;
					count_d = count_q + 1'b1;
				end
			end
			bdeq_pkg::FN_PUSH_BACK: begin
				offset = PTR_W'(count_q);
				if (full) status_d = bdeq_pkg::ST_FULL;
				else begin
					we      = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			bdeq_pkg::FN_POP_FRONT: begin
				if (empty) status_d = bdeq_pkg::ST_EMPTY;
				else begin
					show_d  = 1'b1;
					front_d = front_inc;
					count_d = count_q - 1'b1;
				end
			end
			bdeq_pkg::FN_POP_BACK: begin
				offset = PTR_W'(count_q - 1'b1);
				if (empty) status_d = bdeq_pkg::ST_EMPTY;
				else begin
					show_d  = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			bdeq_pkg::FN_READ_FRONT: begin
				if (empty) status_d = bdeq_pkg::ST_EMPTY;
				else       show_d   = 1'b1;
			end
			bdeq_pkg::FN_READ_BACK: begin
				offset = PTR_W'(count_q - 1'b1);
				if (empty) status_d = bdeq_pkg::ST_EMPTY;
				else       show_d   = 1'b1;
			end
			bdeq_pkg::FN_READ_INDEX: begin
				offset = PTR_W'(position);
				if (pos_bad) status_d = bdeq_pkg::ST_INDEX;
				else         show_d   = 1'b1;
			end
			bdeq_pkg::FN_CLEAR: begin
				front_d = '0;
				count_d = '0;
			end
			default: begin
				front_d = front_q;
			end
		endcase
	end

	// ring store, one port, registered read
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (we) mem[slot] <= value;
			rd_q <= mem[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			show_q   <= show_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	assign data_out = (cmd.respond && show_q) ? rd_q : '0;
	assign status   = status_q;
	assign count    = count_q;

	`BDEQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "element count past depth")
	`BDEQ_ASSERT_NEXT(a_clear, cmd.exec && func == bdeq_pkg::FN_CLEAR, count_q == '0 && front_q == '0, "clear left state")
	`BDEQ_ASSERT_NEXT(a_push_grow, cmd.exec && (func == bdeq_pkg::FN_PUSH_FRONT || func == bdeq_pkg::FN_PUSH_BACK) && !full, count_q == $past(count_q) + 1'b1, "push did not grow count")

endmodule

### hdl/bounded_double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// Bounded double-ended queue of data words held in a single-port ring store.
// ----------------------------------------------------------------------------
// A request word (func, value, position) is taken at the rising edge where
// start is high and busy is low. Its result word (data_out, status, count)
// sits on the ports for exactly one cycle, the cycle right after the accept,
// marked by done; the receiver has no way to hold it off, so it must sample
// data_out, status and count whenever done is high. busy is high in that
// result cycle, so requests do not overlap and a new one can be taken the
// cycle after done: the ring store is one synchronous memory port that is
// written or read at the accept edge, and its registered read data is what
// data_out shows in the next cycle. Push front/back writes one slot; pop and
// read front/back/index read one slot; clear resets the pointer and count.
// status: ok, empty (pop/read on an empty queue), index (position at or past
// count), full (push refused). data_out is zero unless status is ok on a pop
// or read. count is the element count after the request. No init sweep is
// needed after reset: only live slots ever reach data_out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_double_ended_queue_unit #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32,
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          start,
	output logic                          busy,
	input  logic [bdeq_pkg::FUNC_W-1:0]   func,
	input  logic [DATA_WIDTH-1:0]         value,
	input  logic [bdeq_pkg::POS_W-1:0]    position,
	// result side
	output logic                          done,
	output logic [DATA_WIDTH-1:0]         data_out,
	output logic [bdeq_pkg::STATUS_W-1:0] status,
	output logic [CNT_W-1:0]              count
);

	bdeq_pkg::cmd_t cmd;

	// sequencer: idle -> result cycle -> idle
	bdeq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// ring store, pointers and result registers
	bdeq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.func     (func),
		.value    (value),
		.position (position),
		.data_out (data_out),
		.status   (status),
		.count    (count)
	);

endmodule
